@@ rtl/core/cpmdt_pkg.sv @@
`default_nettype none
package cpmdt_pkg;

  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned NORMAL_DEPTH = 61;
  localparam int unsigned FAST_DEPTH   = 6;
  localparam int unsigned SLOW_DEPTH   = 181;
  localparam int unsigned NORMAL_AW    = $clog2(NORMAL_DEPTH);
  localparam int unsigned FAST_AW      = $clog2(FAST_DEPTH);
  localparam int unsigned SLOW_AW      = $clog2(SLOW_DEPTH);

  // floor(x / 3) == (x * RECIP3) >> RECIP3_SHIFT for any 32-bit x
  localparam logic [SAMPLE_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int unsigned         RECIP3_SHIFT = 33;

  localparam logic [SAMPLE_W-1:0] COEF_RESET = 32'd14302;

  localparam int unsigned DIV_STEPS = SAMPLE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // window_mode codes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_FAST   = 2'd1;
  localparam logic [1:0] MODE_SLOW   = 2'd2;

  // opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic REG_WINDOW_MODE    = 1'b0;
  localparam logic REG_DEAD_TIME_COEF = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SCALE,
    ST_RAW,
    ST_PROD,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/cpm_window_dead_time_corrector.sv @@
// Dead-time corrected counts per minute over a moving window.
// Input channel (in_valid / in_stall): one beat per second, either a push of
// the running pulse count or a clear of the three sample rings.
// Result channel (out_valid / out_stall): exactly one beat per input beat.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 window_mode,
// index 1 dead_time_coef; write only while the block is idle.
// Steps: a push reads the oldest ring entry, takes the difference, scales it,
// forms the coefficient product and checks for overflow, then runs the
// 32-step bit-serial divider; the scaling and product steps share one 32x32
// multiplier. A saturating push skips the divider and a clear goes straight
// to the output. One item is in flight at a time: in_stall stays high from
// acceptance until the result is loaded into the output register.
// The output register holds a finished beat while out_stall is high; the next
// item is accepted meanwhile and waits before its own result is loaded.
// Reset (rst_n low, synchronous) empties the rings, zeroes the pointers and
// restores window_mode 0 and dead_time_coef 14302; no clearing pass follows.
`default_nettype none
module cpm_window_dead_time_corrector
  import cpmdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_opcode,
  input  wire logic [SAMPLE_W-1:0] in_count_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [SAMPLE_W-1:0] out_corrected_cpm,
  output logic                     out_saturated,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [SAMPLE_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [1:0]          mode_r;
  logic [SAMPLE_W-1:0] coef_r;

  logic [NORMAL_AW-1:0] normal_ptr_r, normal_ptr_inc;
  logic [FAST_AW-1:0]   fast_ptr_r, fast_ptr_inc;
  logic [SLOW_AW-1:0]   slow_ptr_r, slow_ptr_inc;

  logic [SAMPLE_W-1:0]   sample_r, diff_r, raw_r, res_r;
  logic                  sat_r;
  logic [2*SAMPLE_W-1:0] prod_r, mul_out;
  logic [SAMPLE_W-1:0]   mul_a, mul_b;
  logic [SAMPLE_W-1:0]   old_normal, old_fast, old_slow, old_sel;
  logic [SAMPLE_W:0]     denom;
  logic [SAMPLE_W-1:0]   quotient;
  div_stat_t             div_stat;

  logic in_accept, push, clear, div_start, out_load, over;

  assign in_accept = in_valid && !in_stall;
  assign push      = in_accept && (in_opcode == OP_PUSH);
  assign clear     = in_accept && (in_opcode == OP_CLEAR);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign normal_ptr_inc = (normal_ptr_r == NORMAL_AW'(NORMAL_DEPTH - 1)) ? '0
                        : normal_ptr_r + 1'b1;
  assign fast_ptr_inc   = (fast_ptr_r == FAST_AW'(FAST_DEPTH - 1)) ? '0
                        : fast_ptr_r + 1'b1;
  assign slow_ptr_inc   = (slow_ptr_r == SLOW_AW'(SLOW_DEPTH - 1)) ? '0
                        : slow_ptr_r + 1'b1;

  // write the new sample at the pointer, read the oldest one just past it
  cpmdt_ring_ram #(.DEPTH(NORMAL_DEPTH)) u_normal_ring (
    .clk, .rst_n, .clr(clear),
    .wr_en(push), .wr_addr(normal_ptr_r), .wr_data(in_count_sample),
    .rd_en(push), .rd_addr(normal_ptr_inc), .rd_data(old_normal)
  );

  cpmdt_ring_ram #(.DEPTH(FAST_DEPTH)) u_fast_ring (
    .clk, .rst_n, .clr(clear),
    .wr_en(push), .wr_addr(fast_ptr_r), .wr_data(in_count_sample),
    .rd_en(push), .rd_addr(fast_ptr_inc), .rd_data(old_fast)
  );

  cpmdt_ring_ram #(.DEPTH(SLOW_DEPTH)) u_slow_ring (
    .clk, .rst_n, .clr(clear),
    .wr_en(push), .wr_addr(slow_ptr_r), .wr_data(in_count_sample),
    .rd_en(push), .rd_addr(slow_ptr_inc), .rd_data(old_slow)
  );

  cpmdt_divider u_div (
    .clk, .rst_n,
    .start(div_start),
    .rem_init(raw_r),
    .divisor(denom),
    .stat(div_stat),
    .quotient
  );

  always_comb begin
    case (mode_r)
      MODE_FAST: old_sel = old_fast;
      MODE_SLOW: old_sel = old_slow;
      default:   old_sel = old_normal;
    endcase
  end

  // shared multiplier: reciprocal of three in ST_SCALE, coefficient in ST_PROD
  assign mul_a   = (state_r == ST_SCALE) ? diff_r : raw_r;
  assign mul_b   = (state_r == ST_SCALE) ? RECIP3 : coef_r;
  assign mul_out = {{SAMPLE_W{1'b0}}, mul_a} * {{SAMPLE_W{1'b0}}, mul_b};

  assign denom = {1'b1, {SAMPLE_W{1'b0}}} - {1'b0, prod_r[SAMPLE_W-1:0]};
  // quotient overflows exactly when raw >= denominator; a product past 32 bits also saturates
  assign over  = (prod_r[2*SAMPLE_W-1:SAMPLE_W] != '0) || ({1'b0, raw_r} >= denom);

  assign out_load = (state_r == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (push) begin
          state_nxt = ST_DIFF;
        end else if (clear) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIFF:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_RAW;
      ST_RAW:   state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (over) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      coef_r       <= COEF_RESET;
      normal_ptr_r <= '0;
      fast_ptr_r   <= '0;
      slow_ptr_r   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_MODE:    mode_r <= cfg_data[1:0];
          REG_DEAD_TIME_COEF: coef_r <= cfg_data;
          default:            ;
        endcase
      end
      if (clear) begin
        normal_ptr_r <= '0;
        fast_ptr_r   <= '0;
        slow_ptr_r   <= '0;
      end else if (push) begin
        normal_ptr_r <= normal_ptr_inc;
        fast_ptr_r   <= fast_ptr_inc;
        slow_ptr_r   <= slow_ptr_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sample_r <= in_count_sample;
    end
    case (state_r)
      ST_IDLE: begin
        if (clear) begin
          res_r <= '0;
          sat_r <= 1'b0;
        end
      end
      ST_DIFF:  diff_r <= sample_r - old_sel;
      ST_SCALE: prod_r <= mul_out;
      ST_RAW: begin
        case (mode_r)
          MODE_FAST: raw_r <= (diff_r << 3) + (diff_r << 2);
          MODE_SLOW: raw_r <= SAMPLE_W'(prod_r >> RECIP3_SHIFT);
          default:   raw_r <= diff_r;
        endcase
      end
      ST_PROD: prod_r <= mul_out;
      ST_CHECK: begin
        if (over) begin
          res_r <= '1;
          sat_r <= 1'b1;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          res_r <= quotient;
          sat_r <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_corrected_cpm <= res_r;
      out_saturated     <= sat_r;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted twice in a row");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_corrected_cpm == '1))
    else $error("saturated beat without all-ones result");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(normal_ptr_r) < NORMAL_DEPTH) && (32'(fast_ptr_r) < FAST_DEPTH)
      && (32'(slow_ptr_r) < SLOW_DEPTH))
    else $error("ring pointer out of range");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

@@ rtl/core/cpmdt_ring_ram.sv @@
`default_nettype none
module cpmdt_ring_ram
  import cpmdt_pkg::*;
#(
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clr,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [SAMPLE_W-1:0] wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_r;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entries never written since reset or clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

@@ rtl/core/cpmdt_divider.sv @@
`default_nettype none
module cpmdt_divider
  import cpmdt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [SAMPLE_W-1:0] rem_init,
  input  wire logic [SAMPLE_W:0]   divisor,
  output div_stat_t                stat,
  output logic      [SAMPLE_W-1:0] quotient
);

  // Restoring divide of {rem_init, 32'b0} by divisor, one bit a cycle.
  // Caller guarantees rem_init < divisor, so the quotient fits 32 bits.
  logic [SAMPLE_W:0]    rem_r, rem_nxt;
  logic [SAMPLE_W:0]    den_r;
  logic [SAMPLE_W-1:0]  quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [SAMPLE_W+1:0]  shifted, trial;
  logic                 fits;

  always_comb begin
    shifted = {rem_r, 1'b0};
    trial   = shifted - {1'b0, den_r};
    fits    = shifted >= {1'b0, den_r};
    rem_nxt = fits ? trial[SAMPLE_W:0] : shifted[SAMPLE_W:0];
    quo_nxt = {quo_r[SAMPLE_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, rem_init};
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cpmdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 8;
  localparam logic [31:0] FAST_SCALE   = 32'd12;
  localparam logic [31:0] SLOW_DIVISOR = 32'd3;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;   // no meaning, behaves as normal

  typedef struct packed {
    logic [31:0] cpm;
    logic        sat;
  } cpm_result_t;

  // Tracks ring contents and config, predicts one result per accepted beat
  class cpm_tracker;
    logic [31:0]  normal_ring [NORMAL_DEPTH];
    logic [31:0]  fast_ring [FAST_DEPTH];
    logic [31:0]  slow_ring [SLOW_DEPTH];
    int unsigned  normal_ptr, fast_ptr, slow_ptr;
    logic [1:0]   mode;
    logic [31:0]  coef;
    cpm_result_t  due_q[$];
    int unsigned  errors, n_push, n_clear, n_sat, n_checked;

    function new();
      clear_rings();
      mode = MODE_NORMAL;
      coef = COEF_RESET;
    endfunction

    function void clear_rings();
      foreach (normal_ring[i]) normal_ring[i] = '0;
      foreach (fast_ring[i]) fast_ring[i] = '0;
      foreach (slow_ring[i]) slow_ring[i] = '0;
      normal_ptr = 0;
      fast_ptr   = 0;
      slow_ptr   = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == REG_WINDOW_MODE) mode = data[1:0];
      else coef = data;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function void note_sample(logic op, logic [31:0] sample);
      logic [31:0] old_n, old_f, old_s, diff, raw;
      logic [63:0] prod, denom, quot;
      cpm_result_t r;
      if (op == OP_CLEAR) begin
        clear_rings();
        n_clear++;
        r.cpm = '0;
        r.sat = 1'b0;
        due_q.push_back(r);
        return;
      end
      n_push++;
      // after the write, the slot the pointer lands on is the oldest sample
      normal_ring[normal_ptr] = sample;
      normal_ptr = (normal_ptr + 1) % NORMAL_DEPTH;
      old_n = normal_ring[normal_ptr];
      fast_ring[fast_ptr] = sample;
      fast_ptr = (fast_ptr + 1) % FAST_DEPTH;
      old_f = fast_ring[fast_ptr];
      slow_ring[slow_ptr] = sample;
      slow_ptr = (slow_ptr + 1) % SLOW_DEPTH;
      old_s = slow_ring[slow_ptr];
      case (mode)
        MODE_FAST: begin
          diff = sample - old_f;
          raw  = diff * FAST_SCALE;
        end
        MODE_SLOW: begin
          diff = sample - old_s;
          raw  = diff / SLOW_DIVISOR;
        end
        default: raw = sample - old_n;
      endcase
      prod = {32'b0, coef} * {32'b0, raw};
      if (prod[63:32] != '0) begin
        r.cpm = '1;
        r.sat = 1'b1;
      end else begin
        denom = 64'h1_0000_0000 - prod;
        quot  = {raw, 32'b0} / denom;
        if (quot[63:32] != '0) begin
          r.cpm = '1;
          r.sat = 1'b1;
        end else begin
          r.cpm = quot[31:0];
          r.sat = 1'b0;
        end
      end
      if (r.sat) n_sat++;
      due_q.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_cpm(logic [31:0] cpm, logic sat);
      cpm_result_t want;
      if (due_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat cpm=%h sat=%b", cpm, sat));
        return;
      end
      want = due_q.pop_front();
      n_checked++;
      if (cpm !== want.cpm)
        flag_mismatch($sformatf("corrected_cpm %h, expected %h", cpm, want.cpm));
      if (sat !== want.sat)
        flag_mismatch($sformatf("saturated %b, expected %b", sat, want.sat));
    endtask
  endclass

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic        in_opcode       = OP_PUSH;
  logic [31:0] in_count_sample = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [31:0] out_corrected_cpm;
  logic        out_saturated;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic        cfg_index       = REG_WINDOW_MODE;
  logic [31:0] cfg_data        = '0;

  cpm_tracker  tracker;
  int unsigned cycle_count = 0;
  int unsigned n_settings  = 0;
  int unsigned burst_left  = 0;
  logic [31:0] running     = '0;

  int unsigned stall_style = 0;
  int unsigned style_left  = 0;
  int unsigned stall_run   = 0;
  bit          stall_on    = 1'b0;

  cpm_window_dead_time_corrector dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_count_sample   (in_count_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_corrected_cpm (out_corrected_cpm),
    .out_saturated     (out_saturated),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      tracker.check_cpm(out_corrected_cpm, out_saturated);
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(20, 400);
    end
    style_left--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 60);
          stall_on  = !stall_on;
        end
        stall_run--;
        out_stall <= stall_on;
      end
    endcase
  end

  // one input beat; hold keeps valid up for a back-to-back beat
  task automatic send_item(input logic op, input logic [31:0] sample, input bit hold);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_count_sample <= sample;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_sample(op, sample);
    if (!hold) in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // both registers in back-to-back beats; junk lands in the unused mode bits
  task automatic load_window_config(input logic [1:0] mode, input logic [29:0] junk,
                                    input logic [31:0] coef);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_MODE;
    cfg_data  <= {junk, mode};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(REG_WINDOW_MODE, {junk, mode});
    cfg_index <= REG_DEAD_TIME_COEF;
    cfg_data  <= coef;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_reg(REG_DEAD_TIME_COEF, coef);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned pick, step_max;
    logic        op;
    logic [31:0] sample;
    bit          hold;
    step_max = 20;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: step_max = 20;
          1: step_max = 2000;
          2: step_max = 20000;
          default: step_max = 32'h0100_0000;
        endcase
      end
      pick = $urandom_range(0, 999);
      op   = OP_PUSH;
      if (pick < 3) begin
        op      = OP_CLEAR;
        sample  = $urandom();
        running = $urandom();   // restart the count anywhere, wrap included
      end else if (pick < 30) begin
        sample = $urandom();
      end else begin
        if (pick < 60) running += $urandom();
        else running += $urandom_range(0, step_max);
        sample = running;
      end
      if (burst_left == 0) burst_left = $urandom_range(1, 30);
      burst_left--;
      hold = (burst_left != 0) && (i != n_items - 1);
      send_item(op, sample, hold);
      if (!hold && i != n_items - 1) repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0]  ph_mode;
    logic [31:0] ph_coef;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // default setting: zero rate, full-scale difference, clear, around the
    // nonpositive-denominator boundary
    load_window_config(MODE_NORMAL, '0, COEF_RESET);
    send_item(OP_PUSH, 32'd0, 1'b1);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_PUSH, 32'd1000, 1'b1);
    send_item(OP_PUSH, 32'd301000, 1'b1);
    send_item(OP_PUSH, 32'd300000, 1'b0);
    wait_idle();

    // fast window, zero coefficient passes the scaled rate straight through
    load_window_config(MODE_FAST, '0, 32'd0);
    send_item(OP_CLEAR, 32'd0, 1'b1);
    send_item(OP_PUSH, 32'd10, 1'b1);
    send_item(OP_PUSH, 32'h2000_0000, 1'b0);
    wait_idle();

    // quotient overflow with the smallest nonzero coefficient
    load_window_config(MODE_NORMAL, '0, 32'd1);
    send_item(OP_CLEAR, 32'd0, 1'b1);
    send_item(OP_PUSH, 32'h8000_0000, 1'b1);
    send_item(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
    wait_idle();

    // slow window with the largest coefficient: rate 1 gives denominator 1
    load_window_config(MODE_SLOW, '0, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 32'd0, 1'b1);
    send_item(OP_PUSH, 32'd1, 1'b1);
    send_item(OP_PUSH, 32'd3, 1'b1);
    send_item(OP_PUSH, 32'd2, 1'b0);
    wait_idle();

    // unused selector falls back to the normal window
    load_window_config(MODE_UNUSED, '0, 32'd0);
    send_item(OP_CLEAR, 32'd0, 1'b1);
    send_item(OP_PUSH, 32'd5, 1'b1);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 1'b0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin ph_mode = MODE_NORMAL; ph_coef = COEF_RESET; end
        1: begin ph_mode = MODE_FAST;   ph_coef = $urandom_range(0, 32'h0010_0000); end
        2: begin ph_mode = MODE_SLOW;   ph_coef = 32'd0; end
        3: begin ph_mode = MODE_UNUSED; ph_coef = 32'hFFFF_FFFF; end
        4: begin ph_mode = MODE_FAST;   ph_coef = 32'd1; end
        5: begin ph_mode = MODE_SLOW;   ph_coef = $urandom(); end
        6: begin ph_mode = MODE_NORMAL; ph_coef = $urandom_range(0, 32'h0001_0000); end
        default: begin ph_mode = MODE_SLOW; ph_coef = COEF_RESET; end
      endcase
      load_window_config(ph_mode, 30'($urandom()), ph_coef);
      run_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d sample pushes (%0d saturated), %0d ring clears",
             tracker.n_checked, tracker.n_push, tracker.n_sat, tracker.n_clear);
    $display("Covered %0d window/coefficient settings, %0d mismatches, %0d cycles",
             n_settings, tracker.errors, cycle_count);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
